/* hw/rtl/cbs_pkg.sv */
package cbs_pkg;

   // element width on both channels
   localparam int DATA_W = 32;

   // default buffer depth
   localparam int MAX_ITEMS_DEF = 32;

endpackage

/* hw/rtl/cbs_ram.sv */
module cbs_ram
   import cbs_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = MAX_ITEMS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/combined_list_bubble_sort.sv */
// Combined-list bubble sorter.
//
// Input channel (req_*): one signed 32-bit value per beat, list A first and
// then list B. req_tlast marks the final beat of the batch. Values beyond
// MAX_ITEMS are dropped; a dropped beat with req_tlast still closes the batch.
// Output channel (rsp_*): the n stored values in ascending signed order,
// rsp_tlast high on the last one.
//
// Flow for a batch of n values: loading accepts one beat per cycle. After
// the closing beat req_tready drops while the single compare-swap unit
// walks the buffer in n-1 passes, each latching element 0, stepping the
// carried value along and writing it to the top (none for n = 1). Every
// step writes one RAM element and, but for the last of a pass, reads the
// next. Emission primes the RAM read, then gives one beat per cycle while
// rsp_tready is high; req_tready returns once the last beat sits in the
// output register, so the next batch may load while it waits to be taken.
// A stalled receiver simply holds the output register and the sequencer.
// Reset empties the buffer and the output register; RAM contents are not
// cleared, since only entries written in the current batch are read.
module combined_list_bubble_sort
   import cbs_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // batch_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast    // final_res
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic [2:0] S_LOAD    = 3'd0;
   localparam logic [2:0] S_FIRST   = 3'd1;
   localparam logic [2:0] S_LATCH   = 3'd2;
   localparam logic [2:0] S_STEP    = 3'd3;
   localparam logic [2:0] S_TAIL    = 3'd4;
   localparam logic [2:0] S_EMIT_RD = 3'd5;
   localparam logic [2:0] S_EMIT    = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     pass_ff, pass_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   logic              out_valid_ff, out_valid_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic              in_beat;
   logic              full;
   logic [CW-1:0]     count_after;
   logic [CW-1:0]     last_idx;
   logic [CW-1:0]     pos_ext;
   logic              swap;
   logic              slot_free;

   cbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready  = (state_ff == S_LOAD);
   assign in_beat     = req_tvalid && req_tready;
   assign full        = (fill_ff == CW'(MAX_ITEMS));
   assign count_after = full ? fill_ff : fill_ff + CW'(1);
   assign last_idx    = fill_ff - CW'(1);
   assign pos_ext     = CW'(pos_ff);
   // shared compare unit: carried element against the next stored one
   assign swap        = $signed(cur_ff) > $signed(ram_rdata);
   assign slot_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pass_in      = pass_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = cur_ff;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (in_beat) begin
               if (!full) begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(fill_ff);
                  ram_wdata = req_tdata;
               end
               fill_in = count_after;
               if (req_tlast) begin
                  pos_in   = '0;
                  state_in = (count_after < CW'(2)) ? S_EMIT_RD : S_FIRST;
               end
            end
         end
         S_FIRST: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            pass_in   = '0;
            state_in  = S_LATCH;
         end
         S_LATCH: begin
            // element 0 becomes the carried value, fetch element 1
            cur_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = AW'(1);
            pos_in    = '0;
            state_in  = S_STEP;
         end
         S_STEP: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = swap ? ram_rdata : cur_ff;
            cur_in    = swap ? cur_ff : ram_rdata;
            pos_in    = pos_ff + AW'(1);
            if (pos_ext + CW'(1) == last_idx) begin
               state_in = S_TAIL;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = pos_ff + AW'(2);
            end
         end
         S_TAIL: begin
            // largest of the pass settles at the top
            ram_we    = 1'b1;
            ram_waddr = AW'(last_idx);
            ram_wdata = cur_ff;
            if (pass_ff == last_idx - CW'(1)) begin
               pos_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = '0;
               pass_in   = pass_ff + CW'(1);
               state_in  = S_LATCH;
            end
         end
         S_EMIT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = pos_ff;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = ram_rdata;
               out_last_in  = (pos_ext == last_idx);
               if (pos_ext == last_idx) begin
                  fill_in  = '0;
                  state_in = S_LOAD;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = pos_ff + AW'(1);
                  pos_in    = pos_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // fill count never passes the buffer depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_ITEMS))
      else $error("fill count beyond buffer depth");

   // sort and emit never read the address being written
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("RAM read and write at one address");

   // the sequencer returns to loading only with the final beat
   a_last_on_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && state_in == S_LOAD) |=> (rsp_tvalid && rsp_tlast))
      else $error("batch closed without final beat");

   // sorting runs only on a batch of two or more
   a_sort_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (fill_ff >= CW'(2)))
      else $error("sort step on a short batch");

endmodule
